// ===== hw/rtl/hptd_pkg.sv =====
// Package for the HID page-turn decoder: operation codes, keycode constants,
// request and result payload types, and the keycode helper functions.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hptd_pkg;

   // Field widths.
   localparam int FUNC_W  = 3;
   localparam int LEN_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int KEY_W   = 16;
   localparam int COOL_W  = 16;

   // Operation codes carried in the func field.
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REPORT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LEARN  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CANCEL = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 3'd5;

   // Report length codes.
   localparam logic [LEN_W-1:0] LEN_NONE  = 2'd0;
   localparam logic [LEN_W-1:0] LEN_ONE   = 2'd1;
   localparam logic [LEN_W-1:0] LEN_TWO   = 2'd2;
   localparam logic [LEN_W-1:0] LEN_LONG  = 2'd3;

   // Fixed keyboard and consumer-control keycodes.
   localparam logic [KEY_W-1:0] KEY_RIGHT     = 16'h004F;
   localparam logic [KEY_W-1:0] KEY_LEFT      = 16'h0050;
   localparam logic [KEY_W-1:0] KEY_PAGE_UP   = 16'h004B;
   localparam logic [KEY_W-1:0] KEY_PAGE_DOWN = 16'h004E;
   localparam logic [KEY_W-1:0] CONS_NEXT     = 16'h00B5;
   localparam logic [KEY_W-1:0] CONS_PREV     = 16'h00B6;
   localparam logic [KEY_W-1:0] CONS_FASTF    = 16'h00B3;
   localparam logic [KEY_W-1:0] CONS_REWIND   = 16'h00B4;

   localparam logic [COOL_W-1:0] COOLDOWN_RESET = 16'd300;
   localparam logic [KEY_W-1:0]  TICKS_MAX      = 16'hFFFF;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [LEN_W-1:0]  report_length;
      logic [BYTE_W-1:0] report_byte0;
      logic [BYTE_W-1:0] report_byte1;
      logic [BYTE_W-1:0] report_byte2;
      logic [KEY_W-1:0]  load_back_key;
      logic [KEY_W-1:0]  load_forward_key;
   } req_payload_type;

   typedef struct packed {
      logic             page_back;
      logic             page_forward;
      logic             learn_active;
      logic             learn_done;
      logic [KEY_W-1:0] back_key_now;
      logic [KEY_W-1:0] forward_key_now;
   } rsp_payload_type;

   // Handshake between the input stage and the core.
   typedef struct packed {
      logic valid;
      logic taken;
   } stage_ctrl_type;

   // Extracts the keycode from a report; zero means no key.
   function automatic logic [KEY_W-1:0] report_key(
      input logic [LEN_W-1:0]  len,
      input logic [BYTE_W-1:0] b0,
      input logic [BYTE_W-1:0] b1,
      input logic [BYTE_W-1:0] b2
   );
      logic [KEY_W-1:0] code;
      case (len)
         LEN_LONG: code = {{(KEY_W-BYTE_W){1'b0}}, b2};
         LEN_TWO:  code = {b1, b0};
         LEN_ONE:  code = {{(KEY_W-BYTE_W){1'b0}}, b0};
         default:  code = '0;
      endcase
      return code;
   endfunction

   function automatic logic is_table_forward(input logic [KEY_W-1:0] code);
      return (code == KEY_PAGE_DOWN) || (code == KEY_RIGHT) ||
             (code == CONS_NEXT) || (code == CONS_FASTF);
   endfunction

   function automatic logic is_table_back(input logic [KEY_W-1:0] code);
      return (code == KEY_PAGE_UP) || (code == KEY_LEFT) ||
             (code == CONS_PREV) || (code == CONS_REWIND);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hptd_if.sv =====
// Request and result channel interfaces of the HID page-turn decoder.
// Depends on hptd_pkg for the payload field widths.
`default_nettype none

interface hptd_req_if import hptd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [LEN_W-1:0]  report_length;
   logic [BYTE_W-1:0] report_byte0;
   logic [BYTE_W-1:0] report_byte1;
   logic [BYTE_W-1:0] report_byte2;
   logic [KEY_W-1:0]  load_back_key;
   logic [KEY_W-1:0]  load_forward_key;

   modport source (
      output valid, func, report_length, report_byte0, report_byte1, report_byte2,
             load_back_key, load_forward_key,
      input  ready
   );
   modport sink (
      input  valid, func, report_length, report_byte0, report_byte1, report_byte2,
             load_back_key, load_forward_key,
      output ready
   );
endinterface

interface hptd_rsp_if import hptd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             page_back;
   logic             page_forward;
   logic             learn_active;
   logic             learn_done;
   logic [KEY_W-1:0] back_key_now;
   logic [KEY_W-1:0] forward_key_now;

   modport source (
      output valid, page_back, page_forward, learn_active, learn_done,
             back_key_now, forward_key_now,
      input  ready
   );
   modport sink (
      input  valid, page_back, page_forward, learn_active, learn_done,
             back_key_now, forward_key_now,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/hid_page_turn_decoder.sv =====
// HID page-turn decoder top level: cooldown register, input stage and core.
// Depends on hptd_pkg, hptd_if, hptd_in_stage and hptd_core.
//
// Each request is one operation (millisecond tick, HID report, start or
// cancel learn, clear or load keys) and yields exactly one result with the
// page-back and page-forward pulses, learn status and the current learned
// keys. A request passes an input register and is decoded combinationally
// into the result register, so the block accepts one request per clock
// while the result channel is not stalled; the result register and input
// register let a new request enter while an earlier result still waits.
// The cooldown register resets to 300 and must be written only while no
// request is in flight.
`default_nettype none

module hid_page_turn_decoder import hptd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   hptd_req_if.sink               req_chan,
   hptd_rsp_if.source             rsp_chan,
   input  wire logic              csr_write_enable,
   input  wire logic [COOL_W-1:0] csr_write_data
);

   logic [COOL_W-1:0] cooldown_ff;
   logic [COOL_W-1:0] cooldown_in;
   req_payload_type   req_payload;
   req_payload_type   stage_payload;
   stage_ctrl_type    stage_ctrl;
   rsp_payload_type   rsp_payload;
   logic              stage_taken;
   logic              req_ready;
   logic              rsp_valid;

   // Cooldown configuration register.
   always_comb begin
      cooldown_in = cooldown_ff;
      if (csr_write_enable) begin
         cooldown_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cooldown_ff <= COOLDOWN_RESET;
      end else begin
         cooldown_ff <= cooldown_in;
      end
   end

   // Gather the request fields.
   always_comb begin
      req_payload.func             = req_chan.func;
      req_payload.report_length    = req_chan.report_length;
      req_payload.report_byte0     = req_chan.report_byte0;
      req_payload.report_byte1     = req_chan.report_byte1;
      req_payload.report_byte2     = req_chan.report_byte2;
      req_payload.load_back_key    = req_chan.load_back_key;
      req_payload.load_forward_key = req_chan.load_forward_key;
   end

   hptd_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .stage_taken   (stage_taken),
      .stage_ctrl    (stage_ctrl),
      .stage_payload (stage_payload)
   );

   hptd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .stage_ctrl  (stage_ctrl),
      .item        (stage_payload),
      .cooldown    (cooldown_ff),
      .stage_taken (stage_taken),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_payload)
   );

   assign req_chan.ready           = req_ready;
   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.page_back       = rsp_payload.page_back;
   assign rsp_chan.page_forward    = rsp_payload.page_forward;
   assign rsp_chan.learn_active    = rsp_payload.learn_active;
   assign rsp_chan.learn_done      = rsp_payload.learn_done;
   assign rsp_chan.back_key_now    = rsp_payload.back_key_now;
   assign rsp_chan.forward_key_now = rsp_payload.forward_key_now;

endmodule

`default_nettype wire

// ===== hw/rtl/hptd_in_stage.sv =====
// Input register of the HID page-turn decoder: holds one request until
// the core takes it. Depends on hptd_pkg.
`default_nettype none

module hptd_in_stage import hptd_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire req_payload_type req_payload,
   input  wire logic            stage_taken,
   output      stage_ctrl_type  stage_ctrl,
   output      req_payload_type stage_payload
);

   logic            valid_ff;
   logic            valid_in;
   req_payload_type payload_ff;

   // A new request enters when the register is empty or being emptied.
   assign req_ready = !valid_ff || stage_taken;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         payload_ff <= req_payload;
      end
   end

   assign stage_ctrl.valid = valid_ff;
   assign stage_ctrl.taken = stage_taken;
   assign stage_payload    = payload_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hptd_core.sv =====
// Decoder core: learn state, learned keys, tick counter and the result
// register, all updated in one pass per request. Depends on hptd_pkg.
`default_nettype none

module hptd_core import hptd_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire stage_ctrl_type  stage_ctrl,
   input  wire req_payload_type item,
   input  wire logic [COOL_W-1:0] cooldown,
   output      logic            stage_taken,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   output      rsp_payload_type rsp_payload
);

   logic             learning_ff, learning_in;
   logic             awaiting_ff, awaiting_in;
   logic [KEY_W-1:0] first_ff, first_in;
   logic [KEY_W-1:0] back_key_ff, back_key_in;
   logic [KEY_W-1:0] forward_key_ff, forward_key_in;
   logic [KEY_W-1:0] ticks_ff, ticks_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;
   logic [KEY_W-1:0] code;
   logic             turn_back, turn_forward, done;
   logic             advance;

   // The core takes a request when the result register is free or draining.
   assign advance     = stage_ctrl.valid && (!rsp_valid_ff || rsp_ready);
   assign stage_taken = advance;

   assign code = report_key(item.report_length, item.report_byte0,
                            item.report_byte1, item.report_byte2);

   // Next state and result for the request in the input register.
   always_comb begin
      learning_in    = learning_ff;
      awaiting_in    = awaiting_ff;
      first_in       = first_ff;
      back_key_in    = back_key_ff;
      forward_key_in = forward_key_ff;
      ticks_in       = ticks_ff;
      turn_back      = 1'b0;
      turn_forward   = 1'b0;
      done           = 1'b0;
      case (item.func)
         FUNC_TICK: begin
            if (ticks_ff != TICKS_MAX) begin
               ticks_in = ticks_ff + 1'b1;
            end
         end
         FUNC_REPORT: begin
            if (code != '0) begin
               if (learning_ff) begin
                  if (!awaiting_ff) begin
                     first_in    = code;
                     awaiting_in = 1'b1;
                  end else if (code != first_ff) begin
                     back_key_in    = first_ff;
                     forward_key_in = code;
                     learning_in    = 1'b0;
                     awaiting_in    = 1'b0;
                     done           = 1'b1;
                  end
               end else if (ticks_ff >= cooldown) begin
                  // Learned keys win over the fixed table.
                  if (back_key_ff != '0 && code == back_key_ff) begin
                     turn_back = 1'b1;
                  end else if (forward_key_ff != '0 && code == forward_key_ff) begin
                     turn_forward = 1'b1;
                  end else if (is_table_forward(code)) begin
                     turn_forward = 1'b1;
                  end else if (is_table_back(code)) begin
                     turn_back = 1'b1;
                  end
                  if (turn_back || turn_forward) begin
                     ticks_in = '0;
                  end
               end
            end
         end
         FUNC_LEARN: begin
            learning_in = 1'b1;
            awaiting_in = 1'b0;
            first_in    = '0;
         end
         FUNC_CANCEL: begin
            learning_in = 1'b0;
            awaiting_in = 1'b0;
            first_in    = '0;
         end
         FUNC_CLEAR: begin
            back_key_in    = '0;
            forward_key_in = '0;
         end
         FUNC_LOAD: begin
            back_key_in    = item.load_back_key;
            forward_key_in = item.load_forward_key;
         end
         default: begin
         end
      endcase

      rsp_in.page_back       = turn_back;
      rsp_in.page_forward    = turn_forward;
      rsp_in.learn_active    = learning_in;
      rsp_in.learn_done      = done;
      rsp_in.back_key_now    = back_key_in;
      rsp_in.forward_key_now = forward_key_in;
   end

   // Result valid: set by a taken request, cleared when the result leaves.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         learning_ff    <= 1'b0;
         awaiting_ff    <= 1'b0;
         first_ff       <= '0;
         back_key_ff    <= '0;
         forward_key_ff <= '0;
         ticks_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            learning_ff    <= learning_in;
            awaiting_ff    <= awaiting_in;
            first_ff       <= first_in;
            back_key_ff    <= back_key_in;
            forward_key_ff <= forward_key_in;
            ticks_ff       <= ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Only one direction per result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.page_back && rsp_ff.page_forward))
      else $error("both page directions in one result");

   // Reports during learn mode never turn pages.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.learn_active |-> !rsp_ff.page_back && !rsp_ff.page_forward)
      else $error("page turn while learning");

   // A completed learn leaves two distinct nonzero keys and ends learn mode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.learn_done |->
         !rsp_ff.learn_active && rsp_ff.back_key_now != '0 &&
         rsp_ff.forward_key_now != '0 &&
         rsp_ff.back_key_now != rsp_ff.forward_key_now)
      else $error("bad learn completion");

   // An issued page turn restarts the cooldown count.
   assert property (@(posedge clock) disable iff (reset)
      advance && (turn_back || turn_forward) |=> ticks_ff == '0)
      else $error("tick counter not cleared after page turn");

endmodule

`default_nettype wire
